[rtl/ssxh_pkg.sv]
// Shared types, constants and the mixing function of the sparse string hash.
// Used by the stream interfaces, the stride divider and the top level.
package ssxh_pkg;

	localparam int SAMPLE_DEPTH = 32;
	localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
	localparam int CNT_W = ADDR_W + 1;
	localparam int LEN_W = 32;
	localparam int BYTE_W = 8;
	localparam int HASH_W = 32;
	// The stride is (length >> STRIDE_SHIFT) + 1, so the quotient of
	// (length - 1) / stride always fits in STRIDE_SHIFT bits.
	localparam int STRIDE_SHIFT = 5;
	localparam int STRIDE_W = LEN_W - STRIDE_SHIFT + 1;
	localparam int DIV_CNT_W = $clog2(STRIDE_SHIFT);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_STEP,
		ST_FOLD,
		ST_EMIT
	} state_t;

	function automatic logic [HASH_W-1:0] hash_mix(input logic [HASH_W-1:0] h,
			input logic [BYTE_W-1:0] b);
		logic [HASH_W-1:0] sum;
		sum = (h << 5) + (h >> 2) + HASH_W'(b);
		return h ^ sum;
	endfunction

endpackage

[rtl/ssxh_in_if.sv]
// Valid/ready channel that carries one string byte per word.
// Depends on ssxh_pkg for the field widths.
interface ssxh_in_if;
	logic                          valid;
	logic                          ready;
	logic [ssxh_pkg::BYTE_W-1:0]   data_byte;
	logic [ssxh_pkg::LEN_W-1:0]    total_length;
	logic                          first_item;
	logic                          last_item;

	modport source (output valid, data_byte, total_length, first_item, last_item,
		input ready);
	modport sink (input valid, data_byte, total_length, first_item, last_item,
		output ready);
endinterface

[rtl/ssxh_out_if.sv]
// Valid/ready channel that carries one hash result per word.
// Depends on ssxh_pkg for the field widths.
interface ssxh_out_if;
	logic                          valid;
	logic                          ready;
	logic [ssxh_pkg::HASH_W-1:0]   hash_value;
	logic                          length_mismatch;

	modport source (output valid, hash_value, length_mismatch, input ready);
	modport sink (input valid, hash_value, length_mismatch, output ready);
endinterface

[rtl/sparse_string_shift_xor_hash.sv]
// Sparse string shift-xor hash: a byte without a first mark is handled in the cycle it arrives.
// A first byte of a nonempty string waits while the stride divider runs, then takes its step.
// A last byte adds a fold over the sample RAM, newest kept byte first (count <= 31), or a
// bare pass when nothing was kept, then a load of the output register once it is free.
// An empty string skips the divider and the fold. Reset clears all counters and the
// output valid flag; the sample RAM is not cleared and is read only where written.
module sparse_string_shift_xor_hash (
	input  logic           clk,
	input  logic           arst_n,
	ssxh_in_if.sink        str_chan,
	ssxh_out_if.source     hash_chan
);
	ssxh_pkg::state_t                 state_q, state_d;

	logic [ssxh_pkg::LEN_W-1:0]       decl_q;
	logic [ssxh_pkg::STRIDE_W-1:0]    stride_q;
	logic [ssxh_pkg::STRIDE_W-1:0]    cd_q;
	logic [ssxh_pkg::STRIDE_W-1:0]    init_cd_q;
	logic [ssxh_pkg::LEN_W-1:0]       pos_q;
	logic [ssxh_pkg::CNT_W-1:0]       cnt_q;
	logic [ssxh_pkg::BYTE_W-1:0]      pend_byte_q;
	logic                             pend_last_q;
	logic [ssxh_pkg::HASH_W-1:0]      h_q;
	logic                             mis_q;
	logic [ssxh_pkg::CNT_W-1:0]       idx_q;
	logic                             rd_valid_s1;
	logic [ssxh_pkg::BYTE_W-1:0]      rd_data_s1;
	logic                             out_valid_q;
	logic [ssxh_pkg::HASH_W-1:0]      out_hash_q;
	logic                             out_mis_q;

	logic [ssxh_pkg::BYTE_W-1:0]      sample_mem [ssxh_pkg::SAMPLE_DEPTH];

	logic                             accept;
	logic                             first_acc;
	logic                             empty_acc;
	logic                             step_en;
	logic [ssxh_pkg::BYTE_W-1:0]      step_byte;
	logic                             step_last;
	logic                             keep;
	logic [ssxh_pkg::LEN_W-1:0]       pos_inc;
	logic [ssxh_pkg::CNT_W-1:0]       cnt_next;
	logic [ssxh_pkg::STRIDE_W-1:0]    stride_in;
	logic [ssxh_pkg::ADDR_W-1:0]      rd_addr;
	logic                             fold_done;
	logic                             emit_ok;
	logic                             div_start;
	logic                             div_done;
	logic [ssxh_pkg::STRIDE_W-1:0]    div_rem;

	assign str_chan.ready = (state_q == ssxh_pkg::ST_IDLE);
	assign accept = str_chan.valid && str_chan.ready;
	assign first_acc = accept && str_chan.first_item;
	assign empty_acc = first_acc && (str_chan.total_length == '0);
	assign div_start = first_acc && !empty_acc;
	assign stride_in = ssxh_pkg::STRIDE_W'(str_chan.total_length >> ssxh_pkg::STRIDE_SHIFT)
		+ 1'b1;

	// A continuing byte is handled in the cycle it arrives; the first byte
	// of a string waits in the pending registers until the stride phase is known.
	assign step_en = (accept && !str_chan.first_item) || (state_q == ssxh_pkg::ST_STEP);
	assign step_byte = (state_q == ssxh_pkg::ST_STEP) ? pend_byte_q : str_chan.data_byte;
	assign step_last = (state_q == ssxh_pkg::ST_STEP) ? pend_last_q : str_chan.last_item;

	assign keep = step_en && (cd_q == '0)
		&& (pos_q >= ssxh_pkg::LEN_W'(stride_q - 1'b1))
		&& (pos_q < decl_q)
		&& (cnt_q < ssxh_pkg::CNT_W'(ssxh_pkg::SAMPLE_DEPTH));
	assign pos_inc = pos_q + 1'b1;
	assign cnt_next = cnt_q + ssxh_pkg::CNT_W'(keep);

	assign rd_addr = ssxh_pkg::ADDR_W'(idx_q - 1'b1);
	assign fold_done = (state_q == ssxh_pkg::ST_FOLD) && (idx_q == '0) && !rd_valid_s1;
	assign emit_ok = !out_valid_q || hash_chan.ready;

	ssxh_stride_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (str_chan.total_length - 1'b1),
		.divisor   (stride_in),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssxh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssxh_pkg::ST_IDLE: begin
				if (accept) begin
					if (empty_acc) begin
						state_d = ssxh_pkg::ST_EMIT;
					end else if (str_chan.first_item) begin
						state_d = ssxh_pkg::ST_DIV;
					end else if (str_chan.last_item) begin
						state_d = ssxh_pkg::ST_FOLD;
					end
				end
			end
			ssxh_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = ssxh_pkg::ST_STEP;
				end
			end
			ssxh_pkg::ST_STEP: begin
				state_d = pend_last_q ? ssxh_pkg::ST_FOLD : ssxh_pkg::ST_IDLE;
			end
			ssxh_pkg::ST_FOLD: begin
				if (fold_done) begin
					state_d = ssxh_pkg::ST_EMIT;
				end
			end
			ssxh_pkg::ST_EMIT: begin
				if (emit_ok) begin
					state_d = ssxh_pkg::ST_IDLE;
				end
			end
			default: state_d = ssxh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= '0;
			stride_q <= ssxh_pkg::STRIDE_W'(1);
			cd_q <= '0;
			init_cd_q <= '0;
			pos_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ssxh_pkg::ST_FOLD) && (idx_q != '0);
			if (first_acc) begin
				decl_q <= str_chan.total_length;
				stride_q <= stride_in;
				pos_q <= '0;
				cnt_q <= '0;
				if (empty_acc) begin
					cd_q <= '0;
					init_cd_q <= '0;
				end
			end
			if ((state_q == ssxh_pkg::ST_DIV) && div_done) begin
				cd_q <= div_rem;
				init_cd_q <= div_rem;
			end
			if (step_en) begin
				if (step_last) begin
					// The string ends: rearm with the same declared length.
					cd_q <= init_cd_q;
					pos_q <= '0;
					cnt_q <= '0;
					idx_q <= cnt_next;
				end else begin
					cd_q <= (cd_q == '0) ? stride_q - 1'b1 : cd_q - 1'b1;
					pos_q <= pos_inc;
					cnt_q <= cnt_next;
				end
			end
			if ((state_q == ssxh_pkg::ST_FOLD) && (idx_q != '0)) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (empty_acc) begin
			h_q <= '0;
			mis_q <= 1'b0;
		end else if (step_en && step_last) begin
			h_q <= decl_q;
			mis_q <= (pos_inc != decl_q);
		end else if ((state_q == ssxh_pkg::ST_FOLD) && rd_valid_s1) begin
			h_q <= ssxh_pkg::hash_mix(h_q, rd_data_s1);
		end
		if (first_acc) begin
			pend_byte_q <= str_chan.data_byte;
			pend_last_q <= str_chan.last_item;
		end
	end

	// Sample RAM: kept bytes in arrival order, read back newest first.
	always_ff @(posedge clk) begin
		if (keep) begin
			sample_mem[cnt_q[ssxh_pkg::ADDR_W-1:0]] <= step_byte;
		end
		rd_data_s1 <= sample_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ssxh_pkg::ST_EMIT) && emit_ok) begin
			out_valid_q <= 1'b1;
		end else if (hash_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ssxh_pkg::ST_EMIT) && emit_ok) begin
			out_hash_q <= h_q;
			out_mis_q <= mis_q;
		end
	end

	assign hash_chan.valid = out_valid_q;
	assign hash_chan.hash_value = out_hash_q;
	assign hash_chan.length_mismatch = out_mis_q;
endmodule

[rtl/ssxh_stride_div.sv]
// Restoring divider for (length - 1) mod stride, one quotient bit per cycle.
// Depends on ssxh_pkg for widths; the quotient never exceeds STRIDE_SHIFT bits.
module ssxh_stride_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ssxh_pkg::LEN_W-1:0]     dividend,
	input  logic [ssxh_pkg::STRIDE_W-1:0]  divisor,
	output logic                           done,
	output logic [ssxh_pkg::STRIDE_W-1:0]  remainder
);
	logic                              busy_q;
	logic [ssxh_pkg::DIV_CNT_W-1:0]    bit_q;
	logic [ssxh_pkg::LEN_W-1:0]        rem_q;
	logic [ssxh_pkg::STRIDE_W-1:0]     div_q;
	logic [ssxh_pkg::LEN_W-1:0]        trial;
	logic [ssxh_pkg::LEN_W-1:0]        rem_next;

	// The divisor is captured at start, since the input word moves on after it is accepted.
	always_comb begin
		trial = ssxh_pkg::LEN_W'(div_q) << bit_q;
		if (rem_q >= trial) begin
			rem_next = rem_q - trial;
		end else begin
			rem_next = rem_q;
		end
	end

	assign done = busy_q && (bit_q == '0);
	assign remainder = rem_next[ssxh_pkg::STRIDE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bit_q <= '0;
			rem_q <= '0;
			div_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			bit_q <= ssxh_pkg::DIV_CNT_W'(ssxh_pkg::STRIDE_SHIFT - 1);
			rem_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			if (bit_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				bit_q <= bit_q - 1'b1;
			end
		end
	end
endmodule
